// File: rtl/heq_pkg.sv
// ----------------------------------------------------------------------------
// Histogram equalisation package
// Widths, register indexes, opcodes, state types and small helpers shared by
// the equaliser, its divider and its channel interfaces.
// ----------------------------------------------------------------------------
package heq_pkg;

    localparam int GREY_LEVELS = 256;
    localparam int MAX_SIDE    = 256;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = 17;
    localparam int SUM_W     = 17;
    localparam int BIN_W     = $clog2(GREY_LEVELS);
    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
    localparam int TOT_W     = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int NUM_W     = SUM_W + BIN_W;
    localparam int REM_W     = TOT_W + 1;
    localparam int DCNT_W    = $clog2(BIN_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(80);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(80);

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_MAP   = 1'b1;

    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(GREY_LEVELS - 1);

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_CNT,
        ST_MAP,
        ST_BRD,
        ST_BACC,
        ST_BPREP,
        ST_BDIV
    } t_state;

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } t_div_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [TOT_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [BIN_W-1:0] quot;
    } t_div_rsp;

    // Saturate a grey level onto the last bin
    function automatic logic [BIN_W-1:0] bin_of(input logic [PIX_W-1:0] pixel);
        if (32'(pixel) >= GREY_LEVELS) begin
            return BIN_LAST;
        end
        return BIN_W'(pixel);
    endfunction

    // Force an image side into 1..MAX_SIDE
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return SIDE_W'(1);
        end
        if (32'(v) > MAX_SIDE) begin
            return SIDE_W'(MAX_SIDE);
        end
        return SIDE_W'(v);
    endfunction

endpackage

// File: rtl/heq_in_if.sv
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying an opcode and one grey level per beat.
// ----------------------------------------------------------------------------
interface heq_in_if import heq_pkg::*;;

    logic             valid;
    logic             ready;
    logic             op;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink   (input valid, input op, input pixel, output ready);

endinterface

// File: rtl/heq_out_if.sv
// ----------------------------------------------------------------------------
// Mapped pixel output channel
// Valid/ready channel carrying one equalised grey level per beat.
// ----------------------------------------------------------------------------
interface heq_out_if import heq_pkg::*;;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] mapped_pixel;
    logic             table_ready;

    modport source (output valid, output mapped_pixel, output table_ready, input ready);
    modport sink   (input valid, input mapped_pixel, input table_ready, output ready);

endinterface

// File: rtl/heq_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Produces BIN_W quotient bits of num/den, one bit per cycle. The caller
// guarantees the quotient fits in BIN_W bits (num < den << BIN_W).
// ----------------------------------------------------------------------------
module heq_div import heq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    t_div_state r_state, n_state;

    logic [REM_W-1:0]  r_rem,  n_rem;
    logic [BIN_W-1:0]  r_low,  n_low;
    logic [BIN_W-1:0]  r_quot, n_quot;
    logic [TOT_W-1:0]  r_den,  n_den;
    logic [DCNT_W-1:0] r_cnt,  n_cnt;
    logic              r_done, n_done;

    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] diff;
    logic             fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    always_comb begin
        trial = {r_rem[REM_W-2:0], r_low[BIN_W-1]};
        fits  = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};

        n_state = r_state;
        n_rem   = r_rem;
        n_low   = r_low;
        n_quot  = r_quot;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_done  = 1'b0;

        case (r_state)
            DIV_IDLE: begin
                if (i_req.start) begin
                    n_rem   = REM_W'(i_req.num[NUM_W-1:BIN_W]);
                    n_low   = i_req.num[BIN_W-1:0];
                    n_den   = i_req.den;
                    n_quot  = '0;
                    n_cnt   = DCNT_W'(BIN_W);
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                n_rem  = fits ? diff : trial;
                n_low  = r_low << 1;
                n_quot = (r_quot << 1) | BIN_W'(fits);
                n_cnt  = r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    n_done  = 1'b1;
                    n_state = DIV_IDLE;
                end
            end
            default: begin
                n_state = DIV_IDLE;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// File: rtl/histogram_equalization_8bit.sv
// ----------------------------------------------------------------------------
// Histogram equaliser, 8-bit grey
// Counts a frame of pixels into a histogram, builds the mapping table from the
// cumulative sum and maps pixels through it.
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories to zero and is not ready
// meanwhile; configuration writes are taken at any time. A count beat
// occupies the block for a bin read, then an increment and write back. A map
// beat occupies it for a table read, then the load of the output register,
// which waits for the output register to be free; the result is held in that
// register, so the next input beat can be taken while a result is still
// waiting. The count beat that completes a frame starts the table build,
// which walks every bin with one shared restoring divider: each bin is read,
// added to the running sum and cleared, then its entry is clamped to the top
// level or set to the divider's quotient once the divider is done. No input
// is taken during the build.
module histogram_equalization_8bit import heq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    heq_in_if.sink               i_pix,
    heq_out_if.source            o_map
);

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;
    logic [TOT_W-1:0]  r_total;
    logic [BIN_W-1:0]  r_idx,       n_idx;
    logic [BIN_W-1:0]  r_bin,       n_bin;
    logic [SUM_W-1:0]  r_sum,       n_sum;
    logic [CNT_W-1:0]  r_pix_cnt,   n_pix_cnt;
    logic              r_built,     n_built;
    logic              r_out_valid, n_out_valid;
    logic [PIX_W-1:0]  r_out_pix,   n_out_pix;
    logic              r_out_rdy,   n_out_rdy;

    logic [SUM_W-1:0] r_bin_mem [GREY_LEVELS];
    logic [BIN_W-1:0] r_tab_mem [GREY_LEVELS];
    logic [SUM_W-1:0] r_bin_rd;
    logic [BIN_W-1:0] r_tab_rd;

    logic             bin_re, bin_we, tab_re, tab_we;
    logic [BIN_W-1:0] bin_raddr, bin_waddr, tab_raddr, tab_waddr;
    logic [SUM_W-1:0] bin_wdata;
    logic [BIN_W-1:0] tab_wdata;

    logic [2*SIDE_W-1:0] area;
    logic [CNT_W-1:0]    cnt_inc;
    logic [BIN_W-1:0]    in_bin;
    logic                in_ready;
    logic                advance;

    t_div_req div_req;
    t_div_rsp div_rsp;

    heq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign area = clamp_side(r_width) * clamp_side(r_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_idx       <= '0;
            r_sum       <= '0;
            r_pix_cnt   <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_sum       <= n_sum;
            r_pix_cnt   <= n_pix_cnt;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total   <= TOT_W'(area);
        r_bin     <= n_bin;
        r_out_pix <= n_out_pix;
        r_out_rdy <= n_out_rdy;
    end

    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            r_bin_mem[bin_waddr] <= bin_wdata;
        end
        if (bin_re) begin
            r_bin_rd <= r_bin_mem[bin_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[tab_waddr] <= tab_wdata;
        end
        if (tab_re) begin
            r_tab_rd <= r_tab_mem[tab_raddr];
        end
    end

    always_comb begin
        cnt_inc = r_pix_cnt + CNT_W'(1);
        in_bin  = bin_of(i_pix.pixel);

        n_state     = r_state;
        n_idx       = r_idx;
        n_bin       = r_bin;
        n_sum       = r_sum;
        n_pix_cnt   = r_pix_cnt;
        n_built     = r_built;
        n_out_valid = r_out_valid && !o_map.ready;
        n_out_pix   = r_out_pix;
        n_out_rdy   = r_out_rdy;

        in_ready  = 1'b0;
        advance   = 1'b0;
        bin_re    = 1'b0;
        bin_raddr = r_idx;
        bin_we    = 1'b0;
        bin_waddr = r_idx;
        bin_wdata = '0;
        tab_re    = 1'b0;
        tab_raddr = in_bin;
        tab_we    = 1'b0;
        tab_waddr = r_idx;
        tab_wdata = '0;

        div_req.start = 1'b0;
        div_req.num   = NUM_W'(r_sum) * NUM_W'(GREY_LEVELS);
        div_req.den   = r_total;

        case (r_state)
            ST_CLR: begin
                bin_we = 1'b1;
                tab_we = 1'b1;
                n_idx  = r_idx + BIN_W'(1);
                if (r_idx == BIN_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_pix.valid) begin
                    n_bin = in_bin;
                    if (i_pix.op == OP_MAP) begin
                        tab_re  = 1'b1;
                        n_state = ST_MAP;
                    end else begin
                        bin_re    = 1'b1;
                        bin_raddr = in_bin;
                        n_state   = ST_CNT;
                    end
                end
            end
            ST_CNT: begin
                bin_we    = 1'b1;
                bin_waddr = r_bin;
                bin_wdata = r_bin_rd + SUM_W'(1);
                n_pix_cnt = cnt_inc;
                if (cnt_inc >= r_total) begin
                    n_idx   = '0;
                    n_state = ST_BRD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MAP: begin
                // hold until the output register is free
                if (!r_out_valid || o_map.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = PIX_W'(r_tab_rd);
                    n_out_rdy   = r_built;
                    n_state     = ST_IDLE;
                end
            end
            ST_BRD: begin
                bin_re  = 1'b1;
                n_state = ST_BACC;
            end
            ST_BACC: begin
                // accumulate and clear the bin for the next frame
                n_sum   = r_sum + r_bin_rd;
                bin_we  = 1'b1;
                n_state = ST_BPREP;
            end
            ST_BPREP: begin
                if (r_sum >= r_total) begin
                    tab_we    = 1'b1;
                    tab_wdata = BIN_LAST;
                    advance   = 1'b1;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = ST_BDIV;
                end
            end
            ST_BDIV: begin
                if (div_rsp.done) begin
                    tab_we    = 1'b1;
                    tab_wdata = div_rsp.quot;
                    advance   = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (advance) begin
            if (r_idx == BIN_LAST) begin
                n_idx     = '0;
                n_sum     = '0;
                n_pix_cnt = '0;
                n_built   = 1'b1;
                n_state   = ST_IDLE;
            end else begin
                n_idx   = r_idx + BIN_W'(1);
                n_state = ST_BRD;
            end
        end
    end

    assign i_pix.ready        = in_ready;
    assign o_map.valid        = r_out_valid;
    assign o_map.mapped_pixel = r_out_pix;
    assign o_map.table_ready  = r_out_rdy;

endmodule

// File: rtl/heq_chk.sv
// ----------------------------------------------------------------------------
// Histogram equaliser port checker
// Watches the equaliser's channels and reset behaviour from its ports alone.
// ----------------------------------------------------------------------------
module heq_chk import heq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic [PIX_W-1:0] i_out_pixel,
    input logic i_out_table
);

    logic r_seen_table;
    logic in_beat;

    assign in_beat = i_in_valid && i_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_table <= 1'b0;
        end else if (i_out_valid && i_out_table) begin
            r_seen_table <= 1'b1;
        end
    end

    // reset leaves no result pending and the input closed for the sweep
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("output valid or input ready straight after reset");

    // every input beat occupies the block, so input ready drops once a beat is taken
    a_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !i_in_ready)
        else $error("input taken on consecutive cycles");

    // once a built table has been reported it stays reported
    a_table_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_table |-> i_out_table)
        else $error("table_ready dropped after a build");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pixel))
        else $error("stalled result changed");

endmodule

bind histogram_equalization_8bit heq_chk u_heq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_map.valid),
    .i_out_ready (o_map.ready),
    .i_out_pixel (o_map.mapped_pixel),
    .i_out_table (o_map.table_ready)
);

// File: sim/histogram_equalization_8bit_tb.sv
// ----------------------------------------------------------------------------
// Histogram equaliser testbench
// Streams count and map beats into the equaliser with random gaps and output
// stalls, mirrors the histogram and mapping table in a local model and checks
// every mapped beat in order against it. Covers reset behaviour, one-pixel
// frames, a size change part-way through a frame, a frame with an over-range
// width and a long run of random frames of mixed sizes.
// ----------------------------------------------------------------------------
module histogram_equalization_8bit_tb import heq_pkg::*;;

    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 3500;
    localparam int TAIL_CYCLES   = 3500;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int FULL_ROWS     = 2;
    localparam int MAX_GAP       = 13;

    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic             table_ready;
    } t_mapped;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    heq_in_if  pix_if ();
    heq_out_if map_if ();

    histogram_equalization_8bit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_map      (map_if)
    );

    // Local copy of the equaliser state
    logic [CNT_W-1:0] hist_bins [GREY_LEVELS];
    logic [PIX_W-1:0] level_lut [GREY_LEVELS];
    logic [CNT_W-1:0] pixels_seen;
    logic             lut_built;
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    int unsigned      tables_built;

    t_mapped     pending_levels [$];
    int unsigned items_sent;
    int unsigned fail_count;
    int unsigned quiet_cycles;
    bit          in_idle_on;
    bit          out_idle_on;
    bit          counts_since_cfg;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned eff_side(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > MAX_SIDE) begin
            return MAX_SIDE;
        end
        return int'(v);
    endfunction

    task automatic rebuild_levels(input int unsigned total);
        logic [SUM_W-1:0] cum;
        int unsigned      q;
        cum = '0;
        for (int k = 0; k < GREY_LEVELS; k++) begin
            cum = cum + hist_bins[k];
            q = (32'(cum) * GREY_LEVELS) / total;
            if (q > GREY_LEVELS - 1) begin
                q = GREY_LEVELS - 1;
            end
            level_lut[k] = PIX_W'(q);
        end
        for (int k = 0; k < GREY_LEVELS; k++) begin
            hist_bins[k] = '0;
        end
        pixels_seen = '0;
        lut_built = 1'b1;
        tables_built++;
    endtask

    task automatic equalise_beat(input logic op, input logic [PIX_W-1:0] pix);
        int unsigned b;
        int unsigned total;
        b = pix;
        if (b > GREY_LEVELS - 1) begin
            b = GREY_LEVELS - 1;
        end
        if (op == OP_COUNT) begin
            total = eff_side(cfg_width) * eff_side(cfg_height);
            hist_bins[b] = hist_bins[b] + 1'b1;
            pixels_seen = pixels_seen + 1'b1;
            if (32'(pixels_seen) >= total) begin
                rebuild_levels(total);
            end
        end else begin
            pending_levels.push_back('{level: level_lut[b], table_ready: lut_built});
        end
    endtask

    // Send one beat; valid is left high so a back-to-back beat needs no toggle
    task automatic drive_pixel(input logic op, input logic [PIX_W-1:0] pix);
        int unsigned gap;
        gap = in_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.op    <= op;
        pix_if.pixel <= pix;
        @(posedge i_clk);
        while (!(pix_if.valid && pix_if.ready)) @(posedge i_clk);
        items_sent++;
        if (op == OP_COUNT) begin
            counts_since_cfg = 1'b1;
        end
        equalise_beat(op, pix);
    endtask

    // Drop valid and hold until every mapped beat has come back
    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_levels.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_drained();
        // a frame-completing count may still be building the table
        if (counts_since_cfg) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        cfg_width = w;
        i_cfg_idx  <= REG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        cfg_height = h;
        i_cfg_we <= 1'b0;
        counts_since_cfg = 1'b0;
    endtask

    task automatic test_map_before_build();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        drive_pixel(OP_MAP, 8'h00);
        drive_pixel(OP_MAP, 8'hFF);
        drive_pixel(OP_COUNT, 8'h55);
        drive_pixel(OP_COUNT, 8'hAA);
        drive_pixel(OP_MAP, 8'hAA);
        drive_pixel(OP_MAP, 8'h55);
    endtask

    task automatic test_single_pixel_frames();
        // zero sides are taken as one, so every count closes a frame
        set_size(9'd0, 9'd0);
        drive_pixel(OP_COUNT, 8'h00);
        drive_pixel(OP_MAP, 8'h00);
        drive_pixel(OP_MAP, 8'hFF);
        drive_pixel(OP_COUNT, 8'hFF);
        drive_pixel(OP_MAP, 8'h00);
        drive_pixel(OP_MAP, 8'hFE);
        drive_pixel(OP_MAP, 8'hFF);
    endtask

    task automatic test_size_change_mid_frame();
        set_size(9'd8, 9'd8);
        drive_pixel(OP_COUNT, 8'd3);
        drive_pixel(OP_COUNT, 8'd3);
        drive_pixel(OP_COUNT, 8'd3);
        drive_pixel(OP_COUNT, 8'd100);
        drive_pixel(OP_COUNT, 8'd100);
        drive_pixel(OP_COUNT, 8'd250);
        // shrink below the pixels already counted: next count builds, sums overflow
        set_size(9'd2, 9'd2);
        drive_pixel(OP_COUNT, 8'd0);
        drive_pixel(OP_MAP, 8'd0);
        drive_pixel(OP_MAP, 8'd2);
        drive_pixel(OP_MAP, 8'd3);
        drive_pixel(OP_MAP, 8'd99);
        drive_pixel(OP_MAP, 8'd100);
        drive_pixel(OP_MAP, 8'd255);
    endtask

    task automatic test_full_frame();
        logic [PIX_W-1:0] v;
        v = PIX_W'($urandom_range(0, 255));
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        // over-range width saturates; one bin takes the whole frame
        set_size(9'd511, CFG_W'(FULL_ROWS));
        repeat (MAX_SIDE * FULL_ROWS) drive_pixel(OP_COUNT, v);
        drive_pixel(OP_MAP, 8'h00);
        drive_pixel(OP_MAP, v - 1'b1);
        drive_pixel(OP_MAP, v);
        drive_pixel(OP_MAP, 8'hFF);
        drive_pixel(OP_MAP, PIX_W'($urandom_range(0, 255)));
    endtask

    task automatic random_phase();
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        int unsigned      sel;
        int unsigned      total;
        int unsigned      frames;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      start_builds;
        int               cut;
        int               n_cnt;
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            w = CFG_W'($urandom_range(0, 6));
            h = CFG_W'($urandom_range(0, 6));
        end else if (sel < 95) begin
            w = CFG_W'($urandom_range(1, 24));
            h = CFG_W'($urandom_range(1, 12));
        end else if (sel < 97) begin
            w = CFG_W'($urandom_range(256, 511));
            h = CFG_W'($urandom_range(0, 1));
        end else begin
            w = CFG_W'($urandom_range(0, 1));
            h = CFG_W'($urandom_range(256, 511));
        end
        in_idle_on  = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
        set_size(w, h);
        total  = eff_side(w) * eff_side(h);
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++) begin
            if ($urandom_range(0, 2) == 0) begin
                lo = 0;
                hi = 255;
            end else begin
                lo = $urandom_range(0, 255);
                hi = $urandom_range(lo, 255);
            end
            // now and then leave the last frame unfinished
            cut = (f == frames - 1 && $urandom_range(0, 5) == 0) ?
                  int'($urandom_range(0, total)) : -1;
            n_cnt = 0;
            start_builds = tables_built;
            while (tables_built == start_builds && n_cnt != cut) begin
                if ($urandom_range(0, 19) == 0) begin
                    wait_drained();
                end
                if ($urandom_range(0, 3) == 0) begin
                    drive_pixel(OP_MAP, PIX_W'($urandom_range(0, 255)));
                end else begin
                    drive_pixel(OP_COUNT, PIX_W'($urandom_range(lo, hi)));
                    n_cnt++;
                end
            end
            repeat ($urandom_range(2, 10)) drive_pixel(OP_MAP, PIX_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_frames();
        int unsigned start_items;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) random_phase();
    endtask

    // Output side: when out_idle_on is set, stall at random before a beat
    always begin
        if (out_idle_on && $urandom_range(0, 1) == 1) begin
            map_if.ready <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        map_if.ready <= 1'b1;
        @(posedge i_clk);
        while (!(map_if.valid && map_if.ready)) @(posedge i_clk);
    end

    always @(posedge i_clk) begin
        t_mapped exp_beat;
        if (i_rst_n && map_if.valid && map_if.ready) begin
            if (pending_levels.size() == 0) begin
                $error("unexpected beat: mapped_pixel %0d, table_ready %0d",
                       map_if.mapped_pixel, map_if.table_ready);
                fail_count++;
            end else begin
                exp_beat = pending_levels.pop_front();
                if (map_if.mapped_pixel !== exp_beat.level) begin
                    $error("mapped_pixel: expected %0d, actual %0d",
                           exp_beat.level, map_if.mapped_pixel);
                    fail_count++;
                end
                if (map_if.table_ready !== exp_beat.table_ready) begin
                    $error("table_ready: expected %0d, actual %0d",
                           exp_beat.table_ready, map_if.table_ready);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (map_if.valid && map_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= REG_WIDTH;
        i_cfg_data   <= '0;
        pix_if.valid <= 1'b0;
        pix_if.op    <= OP_COUNT;
        pix_if.pixel <= '0;
        for (int k = 0; k < GREY_LEVELS; k++) begin
            hist_bins[k] = '0;
            level_lut[k] = '0;
        end
        pixels_seen      = '0;
        lut_built        = 1'b0;
        cfg_width        = WIDTH_RST;
        cfg_height       = HEIGHT_RST;
        tables_built     = 0;
        items_sent       = 0;
        in_idle_on       = 1'b1;
        out_idle_on      = 1'b1;
        counts_since_cfg = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_map_before_build();
        test_single_pixel_frames();
        test_size_change_mid_frame();
        test_full_frame();
        test_random_frames();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_levels.size() != 0) begin
            $error("%0d mapped beats never arrived", pending_levels.size());
        end
        if (fail_count == 0 && pending_levels.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
